>>> hw/rtl/tmbc_pkg.sv
`default_nettype none

package tmbc_pkg;

    localparam int POS_W   = 12;
    localparam int SIZE_W  = 8;
    localparam int CELL_W  = 12;
    localparam int COORD_W = 13;
    localparam int WIDTH_W = 9;
    localparam int SHIFT_W = 3;
    localparam int PUSH_W  = 7;
    localparam int IDX_W   = COORD_W + WIDTH_W + 1;
    localparam int CIDX_W  = 17;
    localparam int OFS_W   = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SHIFT = 2'd1;

    localparam logic [WIDTH_W-1:0] MAP_WIDTH_RST  = 9'd32;
    localparam logic [SHIFT_W-1:0] TILE_SHIFT_RST = 3'd3;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT      = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/tmbc_in_if.sv
`default_nettype none

interface tmbc_in_if import tmbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CELL_W-1:0] cell_index;
    logic              cell_solid;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;

    modport source (
        output valid, mode, cell_index, cell_solid, pos_x, pos_y, size_x, size_y,
        input  ready
    );
    modport sink (
        input  valid, mode, cell_index, cell_solid, pos_x, pos_y, size_x, size_y,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/tmbc_out_if.sv
`default_nettype none

interface tmbc_out_if import tmbc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     collided;
    logic signed [PUSH_W-1:0] push_x;
    logic signed [PUSH_W-1:0] push_y;

    modport source (output valid, collided, push_x, push_y, input ready);
    modport sink (input valid, collided, push_x, push_y, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tmbc_ram.sv
`default_nettype none

module tmbc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tile_map_box_collision_unit.sv
// Tile map box collision unit.
// Input channel i_item carries write items (mode 0: one map cell, solid or
// empty) and query items (mode 1: a box given by position and size in pixels).
// Output channel o_result carries one result per query: collided flag and the
// push on each axis that moves the box out of the solid tiles it touches.
// Write items produce no result and leave the unit idle for the next item.
// A query reads the four corner tiles one after another through the single
// port of the map memory (state S_RD), waits for the last read data (S_LAST)
// and forms the result into the output register (S_OUT). The next item is
// taken only once the unit is back in S_IDLE, so a new query is not taken
// before the last one has passed S_OUT.
// The output register lets a query start while an earlier result still waits;
// a query that finishes while the receiver stalls holds in its last step until
// the output register frees.
// Reset sets map_width to 32 and tile_shift to 3 and clears the handshakes.
// The map is not cleared: a cell must be written before a query reads it.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) must be made while idle; the unit does not enforce this.
`default_nettype none

module tile_map_box_collision_unit import tmbc_pkg::*; #(
    parameter int MAP_CELLS = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tmbc_in_if.sink                    i_item,
    tmbc_out_if.source                 o_result
);

    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam logic [CIDX_W-1:0] CELLS_C = CIDX_W'(MAP_CELLS);
    localparam logic [IDX_W-1:0]  CELLS_I = IDX_W'(MAP_CELLS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_LAST = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [WIDTH_W-1:0] r_map_width;
    logic [SHIFT_W-1:0] r_tile_shift;

    logic [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [1:0]         r_k;
    logic [1:0]         r_rd_k;
    logic               r_rd_pend;
    logic               r_rd_inr;
    logic [3:0]         r_solid;

    logic                     r_out_valid;
    logic                     r_out_collided;
    logic signed [PUSH_W-1:0] r_out_push_x;
    logic signed [PUSH_W-1:0] r_out_push_y;

    logic               in_take;
    logic               out_free;
    logic [SHIFT_W-1:0] s_eff;
    logic [SIZE_W-1:0]  sx_fix, sy_fix;
    logic [COORD_W-1:0] cx, cy, col, row;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_inr;
    logic [CIDX_W-1:0]  wr_idx;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_rdata;

    logic [5:0]              tile_sz;
    logic [OFS_W-1:0]        ofs_mask;
    logic signed [PUSH_W-1:0] fwd_x, back_x, fwd_y, back_y;
    logic signed [PUSH_W-1:0] right, left, down, up;

    assign in_take  = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;

    assign i_item.ready      = i_rst_n && (r_state == S_IDLE);
    assign o_result.valid    = r_out_valid;
    assign o_result.collided = r_out_collided;
    assign o_result.push_x   = r_out_push_x;
    assign o_result.push_y   = r_out_push_y;

    assign s_eff  = (r_tile_shift > MAX_SHIFT) ? MAX_SHIFT : r_tile_shift;
    assign sx_fix = (i_item.size_x == '0) ? SIZE_W'(1) : i_item.size_x;
    assign sy_fix = (i_item.size_y == '0) ? SIZE_W'(1) : i_item.size_y;

    // corner address
    assign cx     = r_k[0] ? r_x1 : r_x0;
    assign cy     = r_k[1] ? r_y1 : r_y0;
    assign col    = cx >> s_eff;
    assign row    = cy >> s_eff;
    assign rd_idx = IDX_W'(row) * IDX_W'(r_map_width) + IDX_W'(col);
    assign rd_inr = (rd_idx < CELLS_I);

    assign wr_idx   = CIDX_W'(i_item.cell_index);
    assign ram_we   = in_take && (i_item.mode == MODE_WRITE) && (wr_idx < CELLS_C);
    assign ram_addr = (r_state == S_IDLE) ? wr_idx[ADDR_W-1:0] : rd_idx[ADDR_W-1:0];

    tmbc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item.cell_solid),
        .o_rdata (ram_rdata)
    );

    // push amounts
    assign tile_sz  = 6'd1 << s_eff;
    assign ofs_mask = OFS_W'(tile_sz - 6'd1);
    assign fwd_x    = PUSH_W'(tile_sz) - PUSH_W'(r_x0[OFS_W-1:0] & ofs_mask);
    assign back_x   = PUSH_W'(r_x1[OFS_W-1:0] & ofs_mask) + PUSH_W'(1);
    assign fwd_y    = PUSH_W'(tile_sz) - PUSH_W'(r_y0[OFS_W-1:0] & ofs_mask);
    assign back_y   = PUSH_W'(r_y1[OFS_W-1:0] & ofs_mask) + PUSH_W'(1);
    assign right    = (r_solid[0] || r_solid[2]) ? fwd_x : '0;
    assign left     = (r_solid[1] || r_solid[3]) ? back_x : '0;
    assign down     = (r_solid[0] || r_solid[1]) ? fwd_y : '0;
    assign up       = (r_solid[2] || r_solid[3]) ? back_y : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && i_item.mode == MODE_QUERY) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_k == 2'd3) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_map_width  <= MAP_WIDTH_RST;
            r_tile_shift <= TILE_SHIFT_RST;
            r_k          <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_TILE_SHIFT: r_tile_shift <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_RD) begin
                r_k <= r_k + 2'd1;
            end else begin
                r_k <= '0;
            end
            r_rd_pend <= (r_state == S_RD);

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_item.mode == MODE_QUERY) begin
            r_x0 <= COORD_W'(i_item.pos_x);
            r_y0 <= COORD_W'(i_item.pos_y);
            r_x1 <= COORD_W'(i_item.pos_x) + COORD_W'(sx_fix) - COORD_W'(1);
            r_y1 <= COORD_W'(i_item.pos_y) + COORD_W'(sy_fix) - COORD_W'(1);
        end
        r_rd_k   <= r_k;
        r_rd_inr <= rd_inr;
        if (r_rd_pend) begin
            r_solid[r_rd_k] <= ram_rdata && r_rd_inr;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_collided <= |r_solid;
            r_out_push_x   <= right - left;
            r_out_push_y   <= down - up;
        end
    end

endmodule

`default_nettype wire
